>>> design/wrcd_pkg.sv
// Shared constants and controller/datapath handshake types for the range change detector.
package wrcd_pkg;

    localparam int WINDOW_DEF      = 50;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int THR_BITS        = 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // latch the accepted sample
        logic wr;     // store sample, advance slot and fill count
        logic rd;     // issue one window read
        logic fin;    // compute flag into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic warm;     // item being processed is past warm-up
        logic rd_last;  // read address is at the last window slot
    } t_dp_sts;

endpackage

>>> design/wrcd_ifs.sv
// Channel interfaces: sample input, flag result and threshold configuration.
interface wrcd_smp_if #(
    parameter int SAMPLE_BITS = wrcd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface wrcd_res_if;
    logic valid;
    logic ready;
    logic exceeds_threshold;

    modport source (output valid, output exceeds_threshold, input ready);
    modport sink   (input valid, input exceeds_threshold, output ready);
endinterface

interface wrcd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wrcd_pkg::THR_BITS-1:0] change_threshold;

    modport source (output valid, output change_threshold, input ready);
    modport sink   (input valid, input change_threshold, output ready);
endinterface

>>> design/wrcd_ctrl.sv
// Controller state machine: sequences write, window scan and result handoff.
module wrcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wrcd_pkg::t_dp_cmd o_cmd,
    input  wrcd_pkg::t_dp_sts i_sts
);
    import wrcd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                // warm flag is latched at this edge; decide from the fill count now
                n_state  = i_sts.warm ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/wrcd_dp.sv
// Datapath: window memory, slot and fill counters, running max/min and threshold compare.
module wrcd_dp #(
    parameter int WINDOW      = wrcd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wrcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic                          i_cfg_wr,
    input  logic [wrcd_pkg::THR_BITS-1:0] i_cfg_thr,
    input  wrcd_pkg::t_dp_cmd             i_cmd,
    output wrcd_pkg::t_dp_sts             o_sts,
    output logic                          o_flag
);
    import wrcd_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 2);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] WARM_CNT  = FILL_W'(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];

    logic [THR_BITS-1:0]    r_thr;
    logic [SLOT_W-1:0]      r_slot;
    logic [FILL_W-1:0]      r_fill;
    logic                   r_warm;
    logic [SLOT_W-1:0]      r_rd_addr;
    logic                   r_rd_vld;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic                   r_flag;
    logic [SAMPLE_BITS-1:0] spread;
    logic                   n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_slot    <= '0;
            r_fill    <= '0;
            r_warm    <= 1'b0;
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_thr <= i_cfg_thr;
            end
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.wr) begin
                r_slot    <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                r_warm    <= (r_fill == WARM_CNT);
                r_rd_addr <= '0;
                if (r_fill != WARM_CNT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.rd) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_slot] <= r_sample;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // running extremes start from the identities for max and min
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.wr) begin
            r_hi <= '0;
            r_lo <= '1;
        end else if (r_rd_vld) begin
            if (r_rd_data > r_hi) begin
                r_hi <= r_rd_data;
            end
            if (r_rd_data < r_lo) begin
                r_lo <= r_rd_data;
            end
        end
        if (i_cmd.fin) begin
            r_flag <= n_flag;
        end
    end

    assign spread = r_hi - r_lo;
    assign n_flag = r_warm && (spread > SAMPLE_BITS'(r_thr));

    assign o_sts.warm    = i_cmd.wr ? (r_fill == WARM_CNT) : r_warm;
    assign o_sts.rd_last = (r_rd_addr == LAST_SLOT);
    assign o_flag        = r_flag;

endmodule

>>> design/window_range_change_detector.sv
// Top level of the sliding-window range change detector.
//
//  channel  | dir | signals                      | transfer when
//  i_smp    | in  | valid ready sample_mv        | valid && ready
//  o_res    | out | valid ready exceeds_threshold| valid && ready
//  i_cfg    | in  | valid ready change_threshold | valid && ready (ready tied high)
//
// During warm-up (first WINDOW+1 samples) an item is accepted, written and handed off with no scan.
// After that an item also goes through a window scan: one window memory read port scans
// all WINDOW slots, one per cycle, for max and min.
// Reset is synchronous, active low; it clears counters, threshold and handshakes.
// A pending result sits in the output register; a new sample is accepted meanwhile,
// and the block stalls at its compare step until that result is taken.
module window_range_change_detector #(
    parameter int WINDOW      = wrcd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wrcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrcd_smp_if.sink   i_smp,
    wrcd_res_if.source o_res,
    wrcd_cfg_if.sink   i_cfg
);
    import wrcd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    wrcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    wrcd_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (i_smp.sample_mv),
        .i_cfg_wr  (i_cfg.valid),
        .i_cfg_thr (i_cfg.change_threshold),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_flag    (o_res.exceeds_threshold)
    );

    a_load_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.wr)
        else $error("accepted sample not written next cycle");

    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> o_res.valid)
        else $error("result computed but not presented");

    a_no_scan_in_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sts.warm |-> !cmd.rd)
        else $error("window scan during warm-up");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.wr, cmd.rd, cmd.fin}))
        else $error("more than one datapath command at once");

endmodule
